// ===== hdl/compacting_handle_allocator_unit_macros.svh =====
// assertion macros used by the checker file
`ifndef COMPACTING_HANDLE_ALLOCATOR_UNIT_MACROS_SVH
`define COMPACTING_HANDLE_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, reset masked
`define CHAU_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// next-cycle implication, reset masked
`define CHAU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

// ===== hdl/chau_pkg.sv =====
// shared codes and types of the compacting handle allocator
`default_nettype none
package chau_pkg;
    // request codes
    localparam logic [2:0] REQ_ALLOC = 3'd0;
    localparam logic [2:0] REQ_FREE  = 3'd1;
    localparam logic [2:0] REQ_PIN   = 3'd2;
    localparam logic [2:0] REQ_UNPIN = 3'd3;
    localparam logic [2:0] REQ_QUERY = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_NOHANDLE = 2'd2;
    localparam logic [1:0] ST_BADHANDLE = 2'd3;

    localparam logic [31:0] POOL_SIZE_RESET = 32'd65536;

    // status of the shared modulo unit
    typedef struct packed {
        logic busy;
        logic done;
    } chau_div_stat_t;
endpackage
`default_nettype wire

// ===== hdl/chau_mod_unit.sv =====
// shared bit-serial modulo unit, one dividend bit per cycle
`default_nettype none
module chau_mod_unit #(
    parameter int DW = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [DW-1:0]           dividend,
    input  wire logic [15:0]             divisor,
    output chau_pkg::chau_div_stat_t     stat,
    output logic [15:0]                  rem
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] num_reg, num_next;
    logic [15:0]   den_reg, den_next;
    logic [16:0]   rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [16:0]   trial;

    // one restoring step per cycle
    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[15:0], num_reg[DW-1]};
        if (start)
        begin
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = (trial >= {1'b0, den_reg}) ? trial - {1'b0, den_reg} : trial;
            num_next = num_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // operands
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign rem       = rem_reg[15:0];
endmodule
`default_nettype wire

// ===== hdl/compacting_handle_allocator_unit.sv =====
// Compacting handle allocator: request sequencer, entry table and result register.
// Usage: a request beat (req_type, handle, alloc_size, alignment) is taken when
// req_valid is high and req_stall is low. Each request gives one or more result
// beats on the res_* channel; the final one carries last. Compaction move records
// (is_move set) come before the final beat of an allocate that needed them.
// Free, pin, unpin, query, reserved-code and bad-handle results pass through the
// dispatch state and an entry or final state, which loads them into the output
// register and returns to idle for the next request beat. An allocate runs the
// bump pointer through the shared bit-serial modulo unit. A compaction walks the
// chain with one modulo pass per unpinned entry and steps over pinned entries; a
// walk set-up comes first and a retry with its second modulo pass comes last.
// One request is in flight at a time; req_stall is high until its final result is
// loaded into the output register.
// pool_size is written through pool_size_we / pool_size_data; the user writes it
// only while idle, as the block does not enforce it. Reset empties the table and
// the chain, refills the handle queue with all handles in order, clears the bump
// pointer and sets pool_size and the free count to 65536. While res_stall holds a
// beat, the sequencer waits before it produces the next one; no beat is dropped.
`default_nettype none
module compacting_handle_allocator_unit #(
    parameter int MAX_ENTRIES = 32,
    parameter int ADDR_BITS   = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pool_size_we,
    input  wire logic [31:0] pool_size_data,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [2:0]  req_type,
    input  wire logic [4:0]  handle,
    input  wire logic [30:0] alloc_size,
    input  wire logic [15:0] alignment,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [1:0]       status,
    output logic [4:0]       result_handle,
    output logic [31:0]      address,
    output logic [30:0]      byte_count,
    output logic [31:0]      free_bytes,
    output logic             is_move,
    output logic [31:0]      move_source,
    output logic [31:0]      move_dest,
    output logic             last
);
    localparam int AW = ADDR_BITS;
    localparam int HW = $clog2(MAX_ENTRIES);
    localparam int LW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = (AW + 2 > 34) ? AW + 2 : 34;
    localparam logic [LW-1:0] NUL = LW'(MAX_ENTRIES);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_ADIV   = 4'd2;
    localparam logic [3:0] S_ACALC  = 4'd3;
    localparam logic [3:0] S_ACHK   = 4'd4;
    localparam logic [3:0] S_AGRANT = 4'd5;
    localparam logic [3:0] S_ALINK  = 4'd6;
    localparam logic [3:0] S_CSTART = 4'd7;
    localparam logic [3:0] S_CENT   = 4'd8;
    localparam logic [3:0] S_CDIV   = 4'd9;
    localparam logic [3:0] S_CMOVE  = 4'd10;
    localparam logic [3:0] S_CWR    = 4'd11;
    localparam logic [3:0] S_CNEXT  = 4'd12;
    localparam logic [3:0] S_RETRY  = 4'd13;
    localparam logic [3:0] S_ENTRY  = 4'd14;
    localparam logic [3:0] S_FINAL  = 4'd15;

    // entry tables
    logic [AW-1:0] t_addr  [MAX_ENTRIES];
    logic [30:0]   t_size  [MAX_ENTRIES];
    logic [15:0]   t_align [MAX_ENTRIES];
    logic [15:0]   t_pad   [MAX_ENTRIES];
    logic [LW-1:0] t_prev  [MAX_ENTRIES];
    logic [LW-1:0] t_next  [MAX_ENTRIES];
    logic [HW-1:0] queue_reg [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg, valid_next;
    logic [MAX_ENTRIES-1:0] pinned_reg, pinned_next;

    logic [3:0]    state_reg, state_next;
    logic [31:0]   pool_size_reg;
    logic [2:0]    req_reg, req_next;
    logic [4:0]    hd_reg, hd_next;
    logic [30:0]   size_reg, size_next;
    logic [15:0]   align_reg, align_next;
    logic [15:0]   ralign_reg, ralign_next;
    logic [HW-1:0] idx_reg, idx_next;
    logic [LW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [AW-1:0] bump_reg, bump_next;
    logic [31:0]   fs_reg, fs_next;
    logic [HW-1:0] qhead_reg, qhead_next, qtail_reg, qtail_next;
    logic [LW-1:0] qcount_reg, qcount_next;
    logic [15:0]   pad_reg, pad_next;
    logic [EW-1:0] start_reg, start_next;
    logic [AW-1:0] end_reg, end_next;
    logic [AW-1:0] p_reg, p_next;
    logic [AW-1:0] dst_reg, dst_next;
    logic [LW-1:0] steps_reg, steps_next;
    logic          comp_reg, comp_next;
    logic [1:0]    fin_st_reg, fin_st_next;

    // table write strobes
    logic          full_we, pos_we, prev_we, next_we, q_we;
    logic [HW-1:0] ent_wa, prev_wa, next_wa;
    logic [AW-1:0] addr_wd;
    logic [15:0]   pad_wd;
    logic [LW-1:0] prev_wd, next_wd;

    // result strobe
    logic          emit;
    logic [1:0]    e_status;
    logic [4:0]    e_handle;
    logic [AW-1:0] e_addr, e_src, e_dst;
    logic [30:0]   e_bytes;
    logic          e_move, e_last;
    logic          out_free;

    // modulo unit
    logic                     div_start;
    logic [AW-1:0]            div_num;
    logic [15:0]              div_den;
    chau_pkg::chau_div_stat_t div_stat;
    logic [15:0]              div_rem;
    logic [15:0]              pad_calc;

    // scratch
    logic [EW-1:0] end_w;
    logic          too_big;
    logic [32:0]   back_w;
    logic [31:0]   used_w;
    logic [HW-1:0] hd_idx, gh, nidx, pidx;
    logic [LW-1:0] pl, nl;

    chau_mod_unit #(.DW(AW)) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .stat     (div_stat),
        .rem      (div_rem)
    );

    assign out_free  = !res_valid || !res_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign pad_calc  = (div_rem == 16'd0) ? 16'd0 : align_reg - div_rem;
    assign hd_idx    = HW'(hd_reg);
    assign gh        = queue_reg[qhead_reg];
    assign pl        = t_prev[idx_reg];
    assign nl        = t_next[idx_reg];
    assign pidx      = HW'(pl);
    assign nidx      = HW'(nl);
    assign end_w     = EW'(start_reg) + EW'(size_reg);
    assign too_big   = (end_w >= EW'(pool_size_reg)) || ((end_w >> AW) != '0);
    assign back_w    = 33'(fs_reg) + 33'(t_size[idx_reg]) + 33'(t_pad[idx_reg]);
    assign used_w    = 32'(pad_reg) + 32'(size_reg);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        hd_next     = hd_reg;
        size_next   = size_reg;
        align_next  = align_reg;
        ralign_next = ralign_reg;
        idx_next    = idx_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        bump_next   = bump_reg;
        fs_next     = fs_reg;
        qhead_next  = qhead_reg;
        qtail_next  = qtail_reg;
        qcount_next = qcount_reg;
        pad_next    = pad_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        p_next      = p_reg;
        dst_next    = dst_reg;
        steps_next  = steps_reg;
        comp_next   = comp_reg;
        fin_st_next = fin_st_reg;
        valid_next  = valid_reg;
        pinned_next = pinned_reg;
        full_we = 1'b0; pos_we = 1'b0; prev_we = 1'b0; next_we = 1'b0; q_we = 1'b0;
        ent_wa  = idx_reg; prev_wa = idx_reg; next_wa = idx_reg;
        addr_wd = '0; pad_wd = '0; prev_wd = NUL; next_wd = NUL;
        emit = 1'b0; e_status = chau_pkg::ST_OK; e_handle = '0; e_addr = '0;
        e_bytes = '0; e_move = 1'b0; e_src = '0; e_dst = '0; e_last = 1'b1;
        div_start = 1'b0; div_num = bump_reg; div_den = align_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next    = req_type;
                    hd_next     = handle;
                    size_next   = alloc_size;
                    align_next  = (alignment == 16'd0) ? 16'd1 : alignment;
                    ralign_next = (alignment == 16'd0) ? 16'd1 : alignment;
                    idx_next    = HW'(handle);
                    comp_next   = 1'b0;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                if (req_reg == chau_pkg::REQ_ALLOC)
                begin
                    div_start  = 1'b1;
                    state_next = S_ADIV;
                end
                else if (req_reg > chau_pkg::REQ_QUERY)
                begin
                    fin_st_next = chau_pkg::ST_OK;
                    state_next  = S_FINAL;
                end
                else if (!((32'(hd_reg) < MAX_ENTRIES) && valid_reg[hd_idx]))
                begin
                    fin_st_next = chau_pkg::ST_BADHANDLE;
                    state_next  = S_FINAL;
                end
                else
                begin
                    state_next = S_ENTRY;
                end
            end
            S_ADIV:
            begin
                if (div_stat.done)
                begin
                    pad_next   = pad_calc;
                    state_next = S_ACALC;
                end
            end
            S_ACALC:
            begin
                start_next = EW'(bump_reg) + EW'(pad_reg);
                state_next = S_ACHK;
            end
            S_ACHK:
            begin
                end_next = AW'(end_w);
                if (!too_big)
                    state_next = S_AGRANT;
                else if (comp_reg)
                begin
                    fin_st_next = chau_pkg::ST_NOSPACE;
                    state_next  = S_FINAL;
                end
                else
                    state_next = S_CSTART;
            end
            S_AGRANT:
            begin
                if (qcount_reg == '0)
                begin
                    fin_st_next = chau_pkg::ST_NOHANDLE;
                    state_next  = S_FINAL;
                end
                else
                begin
                    // fill the new entry and pop its handle
                    full_we = 1'b1; ent_wa = gh;
                    addr_wd = AW'(start_reg); pad_wd = pad_reg;
                    prev_we = 1'b1; prev_wa = gh; prev_wd = tail_reg;
                    next_we = 1'b1; next_wa = gh; next_wd = NUL;
                    valid_next[gh]  = 1'b1;
                    pinned_next[gh] = 1'b0;
                    idx_next    = gh;
                    qhead_next  = (qhead_reg == HW'(MAX_ENTRIES - 1)) ? '0 : qhead_reg + 1'b1;
                    qcount_next = qcount_reg - 1'b1;
                    state_next  = S_ALINK;
                end
            end
            S_ALINK:
            begin
                if (out_free)
                begin
                    if (tail_reg != NUL)
                    begin
                        next_we = 1'b1; next_wa = HW'(tail_reg); next_wd = LW'(idx_reg);
                    end
                    else
                        head_next = LW'(idx_reg);
                    tail_next = LW'(idx_reg);
                    bump_next = end_reg;
                    fs_next   = (used_w >= fs_reg) ? 32'd0 : fs_reg - used_w;
                    emit = 1'b1; e_handle = 5'(idx_reg);
                    e_addr = AW'(start_reg); e_bytes = size_reg;
                    state_next = S_IDLE;
                end
            end
            S_CSTART:
            begin
                p_next     = '0;
                steps_next = '0;
                if (head_reg == NUL)
                begin
                    bump_next  = '0;
                    state_next = S_RETRY;
                end
                else
                begin
                    idx_next   = HW'(head_reg);
                    state_next = S_CENT;
                end
            end
            S_CENT:
            begin
                if (pinned_reg[idx_reg])
                begin
                    p_next     = t_addr[idx_reg] + AW'(t_size[idx_reg]);
                    state_next = S_CNEXT;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = p_reg;
                    div_den    = t_align[idx_reg];
                    align_next = t_align[idx_reg];
                    state_next = S_CDIV;
                end
            end
            S_CDIV:
            begin
                if (div_stat.done)
                begin
                    pad_next   = pad_calc;
                    state_next = S_CMOVE;
                end
            end
            S_CMOVE:
            begin
                dst_next   = p_reg + AW'(pad_reg);
                state_next = S_CWR;
            end
            S_CWR:
            begin
                if (out_free || (dst_reg == t_addr[idx_reg]))
                begin
                    pos_we  = 1'b1;
                    addr_wd = dst_reg;
                    pad_wd  = pad_reg;
                    p_next  = dst_reg + AW'(t_size[idx_reg]);
                    if (dst_reg != t_addr[idx_reg])
                    begin
                        emit = 1'b1; e_handle = 5'(idx_reg); e_addr = dst_reg;
                        e_bytes = t_size[idx_reg]; e_move = 1'b1;
                        e_src = t_addr[idx_reg]; e_dst = dst_reg; e_last = 1'b0;
                    end
                    state_next = S_CNEXT;
                end
            end
            S_CNEXT:
            begin
                steps_next = steps_reg + 1'b1;
                if ((nl == NUL) || (steps_reg == LW'(MAX_ENTRIES - 1)))
                begin
                    bump_next  = p_reg;
                    state_next = S_RETRY;
                end
                else
                begin
                    idx_next   = nidx;
                    state_next = S_CENT;
                end
            end
            S_RETRY:
            begin
                // back to the request alignment for the second try
                align_next = ralign_reg;
                div_den    = ralign_reg;
                comp_next  = 1'b1;
                state_next = S_ADIV;
                div_start  = 1'b1;
            end
            S_ENTRY:
            begin
                if (out_free)
                begin
                    if (req_reg == chau_pkg::REQ_FREE)
                    begin
                        // unlink and return the handle
                        if (pl != NUL)
                        begin
                            next_we = 1'b1; next_wa = pidx; next_wd = nl;
                        end
                        else
                            head_next = nl;
                        if (nl != NUL)
                        begin
                            prev_we = 1'b1; prev_wa = nidx; prev_wd = pl;
                        end
                        else
                            tail_next = pl;
                        valid_next[idx_reg]  = 1'b0;
                        pinned_next[idx_reg] = 1'b0;
                        q_we       = 1'b1;
                        qtail_next = (qtail_reg == HW'(MAX_ENTRIES - 1)) ? '0 : qtail_reg + 1'b1;
                        if (qcount_reg < LW'(MAX_ENTRIES))
                            qcount_next = qcount_reg + 1'b1;
                        fs_next = back_w[32] ? 32'hFFFF_FFFF : back_w[31:0];
                    end
                    else if (req_reg == chau_pkg::REQ_PIN)
                        pinned_next[idx_reg] = 1'b1;
                    else if (req_reg == chau_pkg::REQ_UNPIN)
                        pinned_next[idx_reg] = 1'b0;
                    emit = 1'b1; e_handle = hd_reg;
                    e_addr = t_addr[idx_reg]; e_bytes = t_size[idx_reg];
                    state_next = S_IDLE;
                end
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    emit = 1'b1; e_status = fin_st_reg;
                    e_handle = (fin_st_reg == chau_pkg::ST_BADHANDLE) ? hd_reg : 5'd0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pool_size_reg <= chau_pkg::POOL_SIZE_RESET;
            head_reg      <= NUL;
            tail_reg      <= NUL;
            bump_reg      <= '0;
            fs_reg        <= chau_pkg::POOL_SIZE_RESET;
            qhead_reg     <= '0;
            qtail_reg     <= '0;
            qcount_reg    <= LW'(MAX_ENTRIES);
            valid_reg     <= '0;
            pinned_reg    <= '0;
            comp_reg      <= 1'b0;
            res_valid     <= 1'b0;
            for (int i = 0; i < MAX_ENTRIES; i++)
                queue_reg[i] <= HW'(i);
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            bump_reg   <= bump_next;
            fs_reg     <= fs_next;
            qhead_reg  <= qhead_next;
            qtail_reg  <= qtail_next;
            qcount_reg <= qcount_next;
            valid_reg  <= valid_next;
            pinned_reg <= pinned_next;
            comp_reg   <= comp_next;
            if (pool_size_we)
                pool_size_reg <= pool_size_data;
            if (q_we)
                queue_reg[qtail_reg] <= hd_idx;
            if (emit)
                res_valid <= 1'b1;
            else if (!res_stall)
                res_valid <= 1'b0;
        end
    end

    // working registers and entry tables
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        hd_reg     <= hd_next;
        size_reg   <= size_next;
        align_reg  <= align_next;
        ralign_reg <= ralign_next;
        idx_reg    <= idx_next;
        pad_reg    <= pad_next;
        start_reg  <= start_next;
        end_reg    <= end_next;
        p_reg      <= p_next;
        dst_reg    <= dst_next;
        steps_reg  <= steps_next;
        fin_st_reg <= fin_st_next;
        if (full_we || pos_we)
        begin
            t_addr[ent_wa] <= addr_wd;
            t_pad[ent_wa]  <= pad_wd;
        end
        if (full_we)
        begin
            t_size[ent_wa]  <= size_reg;
            t_align[ent_wa] <= align_reg;
        end
        if (prev_we)
            t_prev[prev_wa] <= prev_wd;
        if (next_we)
            t_next[next_wa] <= next_wd;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status        <= e_status;
            result_handle <= e_handle;
            address       <= 32'(e_addr);
            byte_count    <= e_bytes;
            free_bytes    <= fs_next;
            is_move       <= e_move;
            move_source   <= 32'(e_src);
            move_dest     <= 32'(e_dst);
            last          <= e_last;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/chau_checker.sv =====
// port-level checker for the compacting handle allocator, with its bind
`default_nettype none
`include "compacting_handle_allocator_unit_macros.svh"
module chau_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_stall,
    input wire logic        res_valid,
    input wire logic        res_stall,
    input wire logic [1:0]  status,
    input wire logic        is_move,
    input wire logic        last,
    input wire logic [31:0] address
);
    // a stalled result beat holds its payload
    `CHAU_ASSERT_NEXT(a_hold, res_valid && res_stall, res_valid && $stable(address) && $stable(last))
    // one request at a time: busy right after a request beat
    `CHAU_ASSERT_NEXT(a_busy, req_valid && !req_stall, req_stall)
    // move records are never final and always ok
    `CHAU_ASSERT_IMPL(a_move, res_valid && is_move, !last && status == chau_pkg::ST_OK)
    // error results end the request
    `CHAU_ASSERT_IMPL(a_err, res_valid && status != chau_pkg::ST_OK, last && !is_move)
endmodule

bind compacting_handle_allocator_unit chau_checker u_chau_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .status    (status),
    .is_move   (is_move),
    .last      (last),
    .address   (address)
);
`default_nettype wire

// ===== sim/compacting_handle_allocator_unit_tb.sv =====
// self-checking testbench for the compacting handle allocator
`timescale 1ns / 100ps

module compacting_handle_allocator_unit_tb;
    localparam int NUM_ENTRIES = 32;
    localparam int ADDR_BITS   = 32;
    localparam int NULL_LINK   = NUM_ENTRIES;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [2:0] REQ_RSVD_LO = 3'd5;
    localparam logic [2:0] REQ_RSVD_HI = 3'd7;

    // idle patterns
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    typedef struct {
        logic [2:0]  kind;
        logic [4:0]  hnd;
        logic [30:0] size;
        logic [15:0] align;
    } request_t;

    typedef struct {
        logic [1:0]  st;
        logic [4:0]  hnd;
        logic [31:0] addr;
        logic [30:0] bytes;
        logic [31:0] free;
        logic        mv;
        logic [31:0] src;
        logic [31:0] dst;
        logic        fin;
    } outcome_t;

    typedef struct {
        request_t rq;
        bit       typed;
        outcome_t want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        pool_size_we;
    logic [31:0] pool_size_data;
    logic        req_valid;
    logic        req_stall;
    logic [2:0]  req_type;
    logic [4:0]  handle;
    logic [30:0] alloc_size;
    logic [15:0] alignment;
    logic        res_valid;
    logic        res_stall;
    logic [1:0]  status;
    logic [4:0]  result_handle;
    logic [31:0] address;
    logic [30:0] byte_count;
    logic [31:0] free_bytes;
    logic        is_move;
    logic [31:0] move_source;
    logic [31:0] move_dest;
    logic        last;

    compacting_handle_allocator_unit #(
        .MAX_ENTRIES(NUM_ENTRIES),
        .ADDR_BITS  (ADDR_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .pool_size_we  (pool_size_we),
        .pool_size_data(pool_size_data),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_type      (req_type),
        .handle        (handle),
        .alloc_size    (alloc_size),
        .alignment     (alignment),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .status        (status),
        .result_handle (result_handle),
        .address       (address),
        .byte_count    (byte_count),
        .free_bytes    (free_bytes),
        .is_move       (is_move),
        .move_source   (move_source),
        .move_dest     (move_dest),
        .last          (last)
    );

    // allocator mirror state
    logic [63:0] pool_bytes;
    logic [63:0] ent_addr  [NUM_ENTRIES];
    logic [30:0] ent_size  [NUM_ENTRIES];
    logic [15:0] ent_align [NUM_ENTRIES];
    logic [15:0] ent_pad   [NUM_ENTRIES];
    bit          ent_pinned[NUM_ENTRIES];
    bit          ent_live  [NUM_ENTRIES];
    int          ent_prev  [NUM_ENTRIES];
    int          ent_next  [NUM_ENTRIES];
    int          chain_first;
    int          chain_last;
    logic [63:0] bump_ptr;
    logic [31:0] free_count;
    int          handle_fifo[NUM_ENTRIES];
    int          fifo_rd;
    int          fifo_wr;
    int          fifo_fill;

    outcome_t    pending_beats[$];
    dir_row_t    dir_rows[$];
    int          errors;
    int          beats_seen;
    int          moves_seen;
    int          reqs_sent;
    int          idle_mode;
    int          hold_request;
    longint      cycles;

    // clock and cycle limit
    initial
    begin
        clk = 1'b0;
        cycles = 0;
        forever
        begin
            #4 clk = ~clk;
            if (clk)
            begin
                cycles++;
                if (cycles > CYCLE_LIMIT)
                begin
                    $display("timeout after %0d cycles", cycles);
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    // mirror reset
    function automatic void mirror_reset();
        pool_bytes = 64'(chau_pkg::POOL_SIZE_RESET);
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            ent_addr[i] = '0;
            ent_size[i] = '0;
            ent_align[i] = '0;
            ent_pad[i] = '0;
            ent_pinned[i] = 1'b0;
            ent_live[i] = 1'b0;
            ent_prev[i] = 0;
            ent_next[i] = 0;
            handle_fifo[i] = i;
        end
        chain_first = NULL_LINK;
        chain_last = NULL_LINK;
        bump_ptr = '0;
        free_count = chau_pkg::POOL_SIZE_RESET;
        fifo_rd = 0;
        fifo_wr = 0;
        fifo_fill = NUM_ENTRIES;
    endfunction

    function automatic logic [63:0] pad_to(logic [63:0] p, logic [15:0] al);
        logic [63:0] a;
        a = 64'(al);
        return (a - p % a) % a;
    endfunction

    function automatic void push_beat(logic [1:0] st, logic [4:0] h, logic [63:0] addr,
                                      logic [30:0] bytes, logic mv, logic [63:0] src,
                                      logic [63:0] dst, logic fin);
        outcome_t o;
        o.st = st;
        o.hnd = h;
        o.addr = addr[31:0];
        o.bytes = bytes;
        o.free = free_count;
        o.mv = mv;
        o.src = src[31:0];
        o.dst = dst[31:0];
        o.fin = fin;
        pending_beats.push_back(o);
    endfunction

    // slide unpinned entries down, one move beat per relocated entry
    function automatic void compact_pool();
        logic [63:0] p;
        logic [63:0] pad;
        logic [63:0] dst;
        logic [63:0] src;
        logic [15:0] al;
        int h;
        int steps;
        p = '0;
        h = chain_first;
        steps = 0;
        while (h < NUM_ENTRIES && steps < NUM_ENTRIES)
        begin
            if (ent_pinned[h])
                p = ent_addr[h] + 64'(ent_size[h]);
            else
            begin
                al = (ent_align[h] == 0) ? 16'd1 : ent_align[h];
                pad = pad_to(p, al);
                dst = p + pad;
                src = ent_addr[h];
                ent_addr[h] = dst;
                ent_pad[h] = pad[15:0];
                p = dst + 64'(ent_size[h]);
                if (src != dst)
                    push_beat(chau_pkg::ST_OK, 5'(h), dst, ent_size[h], 1'b1, src, dst, 1'b0);
            end
            h = ent_next[h];
            steps++;
        end
        bump_ptr = p;
    endfunction

    // expected beats for one accepted request
    function automatic void predict_request(request_t rq);
        logic [15:0] al;
        logic [63:0] pad;
        logic [63:0] start;
        logic [63:0] stop;
        logic [63:0] used;
        logic [63:0] back;
        int h;
        int pv;
        int nx;
        if (rq.kind == chau_pkg::REQ_ALLOC)
        begin
            al = (rq.align == 0) ? 16'd1 : rq.align;
            pad = pad_to(bump_ptr, al);
            start = bump_ptr + pad;
            stop = start + 64'(rq.size);
            if (stop >= pool_bytes)
            begin
                compact_pool();
                pad = pad_to(bump_ptr, al);
                start = bump_ptr + pad;
                stop = start + 64'(rq.size);
                if (stop >= pool_bytes)
                begin
                    push_beat(chau_pkg::ST_NOSPACE, '0, '0, '0, 1'b0, '0, '0, 1'b1);
                    return;
                end
            end
            if (fifo_fill == 0)
            begin
                push_beat(chau_pkg::ST_NOHANDLE, '0, '0, '0, 1'b0, '0, '0, 1'b1);
                return;
            end
            h = handle_fifo[fifo_rd];
            fifo_rd = (fifo_rd + 1) % NUM_ENTRIES;
            fifo_fill--;
            used = pad + 64'(rq.size);
            free_count = (used >= 64'(free_count)) ? '0 : free_count - used[31:0];
            ent_addr[h] = start;
            ent_size[h] = rq.size;
            ent_align[h] = al;
            ent_pad[h] = pad[15:0];
            ent_pinned[h] = 1'b0;
            ent_live[h] = 1'b1;
            ent_next[h] = NULL_LINK;
            ent_prev[h] = chain_last;
            if (chain_last < NUM_ENTRIES)
                ent_next[chain_last] = h;
            else
                chain_first = h;
            chain_last = h;
            bump_ptr = stop;
            push_beat(chau_pkg::ST_OK, 5'(h), start, rq.size, 1'b0, '0, '0, 1'b1);
            return;
        end
        if (rq.kind > chau_pkg::REQ_QUERY)
        begin
            push_beat(chau_pkg::ST_OK, '0, '0, '0, 1'b0, '0, '0, 1'b1);
            return;
        end
        h = rq.hnd;
        if (!ent_live[h])
        begin
            push_beat(chau_pkg::ST_BADHANDLE, rq.hnd, '0, '0, 1'b0, '0, '0, 1'b1);
            return;
        end
        if (rq.kind == chau_pkg::REQ_FREE)
        begin
            pv = ent_prev[h];
            nx = ent_next[h];
            back = 64'(free_count) + 64'(ent_size[h]) + 64'(ent_pad[h]);
            if (pv < NUM_ENTRIES)
                ent_next[pv] = nx;
            else
                chain_first = nx;
            if (nx < NUM_ENTRIES)
                ent_prev[nx] = pv;
            else
                chain_last = pv;
            ent_pinned[h] = 1'b0;
            ent_live[h] = 1'b0;
            handle_fifo[fifo_wr] = h;
            fifo_wr = (fifo_wr + 1) % NUM_ENTRIES;
            if (fifo_fill < NUM_ENTRIES)
                fifo_fill++;
            free_count = (back > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : back[31:0];
        end
        else if (rq.kind == chau_pkg::REQ_PIN)
            ent_pinned[h] = 1'b1;
        else if (rq.kind == chau_pkg::REQ_UNPIN)
            ent_pinned[h] = 1'b0;
        push_beat(chau_pkg::ST_OK, rq.hnd, ent_addr[h], ent_size[h], 1'b0, '0, '0, 1'b1);
    endfunction

    // offer one request beat; entered and left at a falling edge
    task automatic offer_request(request_t rq, bit typed, outcome_t want);
        int gap;
        gap = 0;
        if (idle_mode == IDLE_SEND)
            while ($urandom_range(99) < 47 && gap < 20)
                gap++;
        else if (idle_mode == IDLE_BOTH)
            while ($urandom_range(99) < 8 && gap < 20)
                gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_type <= rq.kind;
        handle <= rq.hnd;
        alloc_size <= rq.size;
        alignment <= rq.align;
        do
            @(posedge clk);
        while (req_stall);
        predict_request(rq);
        if (typed)
        begin
            void'(pending_beats.pop_back());
            pending_beats.push_back(want);
        end
        reqs_sent++;
        @(negedge clk);
    endtask

    // drain outstanding beats, then let the block settle
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(negedge clk);
        repeat (ADDR_BITS + 10) @(negedge clk);
    endtask

    task automatic write_pool_size(logic [31:0] value);
        pool_size_we <= 1'b1;
        pool_size_data <= value;
        @(negedge clk);
        pool_size_we <= 1'b0;
        pool_bytes = 64'(value);
    endtask

    function automatic int pick_live();
        int live_list[$];
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (ent_live[i])
                live_list.push_back(i);
        if (live_list.size() == 0)
            return $urandom_range(NUM_ENTRIES - 1);
        return live_list[$urandom_range(live_list.size() - 1)];
    endfunction

    function automatic request_t random_request();
        request_t rq;
        int roll;
        roll = $urandom_range(99);
        rq.hnd = 5'($urandom);
        rq.size = 31'($urandom_range(300));
        rq.align = 16'(1 << $urandom_range(6));
        if (roll < 42)
            rq.kind = chau_pkg::REQ_ALLOC;
        else if (roll < 64)
            rq.kind = chau_pkg::REQ_FREE;
        else if (roll < 74)
            rq.kind = chau_pkg::REQ_PIN;
        else if (roll < 84)
            rq.kind = chau_pkg::REQ_UNPIN;
        else if (roll < 95)
            rq.kind = chau_pkg::REQ_QUERY;
        else
            rq.kind = 3'($urandom_range(REQ_RSVD_HI, REQ_RSVD_LO));
        if (rq.kind != chau_pkg::REQ_ALLOC && $urandom_range(99) < 85)
            rq.hnd = 5'(pick_live());
        // occasional wide fields so every bit toggles
        if ($urandom_range(99) < 6)
            rq.size = 31'($urandom);
        if ($urandom_range(99) < 10)
            rq.align = 16'($urandom);
        return rq;
    endfunction

    function automatic void add_row(logic [2:0] kind, logic [4:0] h, logic [30:0] size,
                                    logic [15:0] al, bit typed, logic [1:0] st,
                                    logic [4:0] rh, logic [31:0] addr, logic [30:0] bytes,
                                    logic [31:0] free);
        dir_row_t r;
        r.rq.kind = kind;
        r.rq.hnd = h;
        r.rq.size = size;
        r.rq.align = al;
        r.typed = typed;
        r.want.st = st;
        r.want.hnd = rh;
        r.want.addr = addr;
        r.want.bytes = bytes;
        r.want.free = free;
        r.want.mv = 1'b0;
        r.want.src = '0;
        r.want.dst = '0;
        r.want.fin = 1'b1;
        dir_rows.push_back(r);
    endfunction

    // receiver stall generator with a long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        res_stall = 1'b1;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else if (idle_mode == IDLE_RECV)
                res_stall <= ($urandom_range(99) < 47);
            else if (idle_mode == IDLE_BOTH)
                res_stall <= ($urandom_range(99) < 8);
            else
                res_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        outcome_t w;
        if (rst_n && res_valid && !res_stall)
        begin
            beats_seen++;
            if (is_move)
                moves_seen++;
            if (pending_beats.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, status %0d handle %0d",
                         $time, status, result_handle);
            end
            else
            begin
                w = pending_beats.pop_front();
                if (status !== w.st || result_handle !== w.hnd || address !== w.addr ||
                    byte_count !== w.bytes || free_bytes !== w.free || is_move !== w.mv ||
                    move_source !== w.src || move_dest !== w.dst || last !== w.fin)
                begin
                    errors++;
                    $display({"%0t: mismatch expected st=%0d h=%0d addr=%h bytes=%h",
                              " free=%h mv=%0d src=%h dst=%h last=%0d"},
                             $time, w.st, w.hnd, w.addr, w.bytes, w.free, w.mv, w.src,
                             w.dst, w.fin);
                    $display({"%0t:          actual st=%0d h=%0d addr=%h bytes=%h",
                              " free=%h mv=%0d src=%h dst=%h last=%0d"},
                             $time, status, result_handle, address, byte_count, free_bytes,
                             is_move, move_source, move_dest, last);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        logic [31:0] pool_plan[5];
        request_t rq;
        outcome_t none;
        errors = 0;
        beats_seen = 0;
        moves_seen = 0;
        reqs_sent = 0;
        idle_mode = IDLE_NONE;
        hold_request = 0;
        none = '{default: '0};
        rst_n = 1'b0;
        pool_size_we = 1'b0;
        pool_size_data = '0;
        req_valid = 1'b0;
        req_type = chau_pkg::REQ_QUERY;
        handle = '0;
        alloc_size = '0;
        alignment = 16'd1;
        mirror_reset();

        // directed rows: reset state, reserved codes, extremes, compaction
        add_row(chau_pkg::REQ_QUERY, 5'd0, '0, 16'd1, 1, chau_pkg::ST_BADHANDLE,
                5'd0, '0, '0, 32'd65536);
        add_row(chau_pkg::REQ_FREE, 5'd31, '0, 16'd1, 1, chau_pkg::ST_BADHANDLE,
                5'd31, '0, '0, 32'd65536);
        add_row(REQ_RSVD_LO, 5'd31, 31'h7FFF_FFFF, 16'hFFFF, 1, chau_pkg::ST_OK,
                '0, '0, '0, 32'd65536);
        add_row(REQ_RSVD_HI, 5'd3, '0, 16'd1, 1, chau_pkg::ST_OK, '0, '0, '0, 32'd65536);
        add_row(chau_pkg::REQ_ALLOC, '0, '0, 16'd0, 1, chau_pkg::ST_OK,
                5'd0, '0, '0, 32'd65536);
        add_row(chau_pkg::REQ_ALLOC, '0, 31'd100, 16'd1, 1, chau_pkg::ST_OK,
                5'd1, '0, 31'd100, 32'd65436);
        add_row(chau_pkg::REQ_ALLOC, '0, 31'd8, 16'd16, 1, chau_pkg::ST_OK,
                5'd2, 32'd112, 31'd8, 32'd65416);
        add_row(chau_pkg::REQ_PIN, 5'd1, '0, 16'd1, 1, chau_pkg::ST_OK,
                5'd1, '0, 31'd100, 32'd65416);
        add_row(chau_pkg::REQ_UNPIN, 5'd2, '0, 16'd1, 1, chau_pkg::ST_OK,
                5'd2, 32'd112, 31'd8, 32'd65416);
        add_row(chau_pkg::REQ_QUERY, 5'd2, '0, 16'd1, 1, chau_pkg::ST_OK,
                5'd2, 32'd112, 31'd8, 32'd65416);
        add_row(chau_pkg::REQ_ALLOC, '0, 31'h7FFF_FFFF, 16'hFFFF, 0, '0, '0, '0, '0, '0);
        add_row(chau_pkg::REQ_FREE, 5'd1, '0, 16'd1, 1, chau_pkg::ST_OK,
                5'd1, '0, 31'd100, 32'd65516);
        add_row(chau_pkg::REQ_ALLOC, '0, 31'd1, 16'hFFFF, 0, '0, '0, '0, '0, '0);
        add_row(chau_pkg::REQ_ALLOC, '0, 31'd300, 16'd3, 0, '0, '0, '0, '0, '0);
        add_row(chau_pkg::REQ_PIN, 5'd3, '0, 16'd1, 0, '0, '0, '0, '0, '0);
        add_row(chau_pkg::REQ_FREE, 5'd0, '0, 16'd1, 0, '0, '0, '0, '0, '0);
        add_row(chau_pkg::REQ_ALLOC, '0, 31'd65000, 16'd1, 0, '0, '0, '0, '0, '0);
        add_row(chau_pkg::REQ_ALLOC, '0, 31'd200, 16'd8, 0, '0, '0, '0, '0, '0);
        add_row(chau_pkg::REQ_UNPIN, 5'd3, '0, 16'd1, 0, '0, '0, '0, '0, '0);
        add_row(chau_pkg::REQ_ALLOC, '0, 31'd65300, 16'd1, 0, '0, '0, '0, '0, '0);
        add_row(chau_pkg::REQ_QUERY, 5'd4, '0, 16'd1, 0, '0, '0, '0, '0, '0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            offer_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);

        // random phases, each with its own pool size and one of the four idle patterns
        pool_plan[0] = 32'd4096;
        pool_plan[1] = chau_pkg::POOL_SIZE_RESET;
        pool_plan[2] = 32'd1;
        pool_plan[3] = 32'hFFFF_FFFF;
        pool_plan[4] = 32'd1024 + ($urandom & 32'h3FFF);
        for (int ph = 0; ph < 5; ph++)
        begin
            wait_idle();
            write_pool_size(pool_plan[ph]);
            idle_mode = ph % 4;
            if (ph == 0)
                hold_request = HOLD_CYCLES;
            for (int n = 0; n < 50; n++)
            begin
                rq = random_request();
                offer_request(rq, 0, none);
            end
        end

        wait_idle();
        repeat (200) @(negedge clk);
        $display("%0d requests sent, %0d result beats checked including %0d move records",
                 reqs_sent, beats_seen, moves_seen);
        $display("pool sizes 1 to 2^32-1, all request codes, four idle patterns, one long hold-off");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
